### hdl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// shared widths, command and result codes, cell entry and control types for
// the sorted deadline timer queue
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 4;
    localparam int TIME_W = 64;
    localparam int KIND_W = 2;

    // timer ids are carried in ID_W bits, so no more ids than this exist
    localparam int MAX_IDS = 1 << ID_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_ABS = 3'd0,
        CMD_SET_REL = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_ADVANCE = 3'd3,
        CMD_QUERY   = 3'd4
    } command_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK       = 2'd0,
        KIND_EXPIRED   = 2'd1,
        KIND_REMAINING = 2'd2
    } kind_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] when;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

    // what the controller sees of the front of the queue
    typedef struct packed {
        logic            head_due;
        logic [ID_W-1:0] head_id;
        logic            next_due;
    } chain_status_t;

endpackage

### hdl/sdtq_in_if.sv
// ----------------------------------------------------------------------------
// sdtq_in_if
// command channel: valid/ready handshake with one command per beat
// ----------------------------------------------------------------------------
interface sdtq_in_if;

    logic                        valid;
    logic                        ready;
    logic [sdtq_pkg::CMD_W-1:0]  command;
    logic [sdtq_pkg::ID_W-1:0]   timer_id;
    logic [sdtq_pkg::TIME_W-1:0] time_value;
    logic [sdtq_pkg::TIME_W-1:0] now;

    modport source (
        output valid,
        output command,
        output timer_id,
        output time_value,
        output now,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  timer_id,
        input  time_value,
        input  now,
        output ready
    );

endinterface

### hdl/sdtq_out_if.sv
// ----------------------------------------------------------------------------
// sdtq_out_if
// result channel: valid/ready handshake with one result per beat
// ----------------------------------------------------------------------------
interface sdtq_out_if;

    logic                        valid;
    logic                        ready;
    logic [sdtq_pkg::KIND_W-1:0] kind;
    logic [sdtq_pkg::ID_W-1:0]   out_timer_id;
    logic                        was_pending;
    logic [sdtq_pkg::TIME_W-1:0] remaining;
    logic                        last;

    modport source (
        output valid,
        output kind,
        output out_timer_id,
        output was_pending,
        output remaining,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  out_timer_id,
        input  was_pending,
        input  remaining,
        input  last,
        output ready
    );

endinterface

### hdl/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// timers kept in a shifting chain of cells ordered by 64-bit deadline
// steps: delete and query go to the response state, set goes through the
//   link state first, advance pops due timers; back-pressure stalls the output
// throughput: one command at a time, ready only while the controller is idle
// reset: async active low clears the fsm, the output beat, the pending flags
//   and the cell valid bits at once; deadlines need no clearing pass
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
    parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sdtq_in_if.sink           cmd_chan,
    sdtq_out_if.source        res_chan
);

    // only ids that fit the id field and lie below NUM_TIMERS are usable
    localparam int NUM_IDS = (NUM_TIMERS < sdtq_pkg::MAX_IDS) ? NUM_TIMERS
                                                              : sdtq_pkg::MAX_IDS;
    localparam int IDX_W   = $clog2(NUM_IDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_RESP,
        S_DRAIN
    } state_t;

    state_t                          state_reg;
    logic [sdtq_pkg::ID_W-1:0]       id_reg;
    logic [sdtq_pkg::TIME_W-1:0]     when_reg;
    logic [sdtq_pkg::TIME_W-1:0]     now_reg;
    logic                            ok_reg;
    logic                            was_reg;
    sdtq_pkg::kind_t                 kind_sel_reg;
    logic [NUM_IDS-1:0]              pending_reg;

    // result beat register
    logic                            out_valid_reg;
    sdtq_pkg::kind_t                 out_kind_reg;
    logic [sdtq_pkg::ID_W-1:0]       out_id_reg;
    logic                            out_wp_reg;
    logic [sdtq_pkg::TIME_W-1:0]     out_rem_reg;
    logic                            out_last_reg;

    // last deadline written per timer, read by queries
    logic [sdtq_pkg::TIME_W-1:0]     dl_mem [NUM_IDS];

    sdtq_pkg::cell_cmd_t             cell_cmd;
    sdtq_pkg::chain_status_t         status;

    logic                            accept;
    logic                            id_ok;
    logic [IDX_W-1:0]                in_idx;
    logic [IDX_W-1:0]                idx;
    logic [IDX_W-1:0]                head_idx;
    logic                            was_now;
    logic                            out_free;
    logic                            out_load;
    logic [sdtq_pkg::TIME_W-1:0]     rd_deadline;
    logic [sdtq_pkg::TIME_W-1:0]     rem;

    assign accept   = cmd_chan.valid && cmd_chan.ready;
    assign id_ok    = int'(cmd_chan.timer_id) < NUM_TIMERS;
    assign in_idx   = cmd_chan.timer_id[IDX_W-1:0];
    assign idx      = id_reg[IDX_W-1:0];
    assign head_idx = status.head_id[IDX_W-1:0];
    assign was_now  = id_ok && pending_reg[in_idx];
    assign out_free = !out_valid_reg || res_chan.ready;

    // a new result beat goes into the output register this cycle
    assign out_load = out_free && ((state_reg == S_RESP) ||
                                   (state_reg == S_DRAIN && status.head_due));

    // saturating remaining time, zero for an id out of range
    assign rd_deadline = dl_mem[idx];
    assign rem = (ok_reg && (rd_deadline > now_reg)) ? (rd_deadline - now_reg) : '0;

    // the chain of cells: unlink straight from the accepted beat, insert in
    // the next cycle so that it sees the queue already closed up
    always_comb
    begin
        cell_cmd.op   = sdtq_pkg::OP_HOLD;
        cell_cmd.id   = (state_reg == S_IDLE) ? cmd_chan.timer_id : id_reg;
        cell_cmd.when = when_reg;
        cell_cmd.now  = now_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && was_now &&
                    (cmd_chan.command == sdtq_pkg::CMD_SET_ABS ||
                     cmd_chan.command == sdtq_pkg::CMD_SET_REL ||
                     cmd_chan.command == sdtq_pkg::CMD_DELETE))
                begin
                    cell_cmd.op = sdtq_pkg::OP_REMOVE;
                end
            end
            S_LINK:
            begin
                cell_cmd.op = sdtq_pkg::OP_INSERT;
            end
            S_DRAIN:
            begin
                if (out_free && status.head_due)
                begin
                    cell_cmd.op = sdtq_pkg::OP_POP;
                end
            end
            default:
            begin
                cell_cmd.op = sdtq_pkg::OP_HOLD;
            end
        endcase
    end

    sdtq_chain #(
        .NUM_CELLS (NUM_TIMERS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cell_cmd),
        .status (status)
    );

    // deadline store, written as the timer goes into the chain
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LINK)
        begin
            dl_mem[idx] <= when_reg;
        end
    end

    // controller and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            id_reg        <= '0;
            when_reg      <= '0;
            now_reg       <= '0;
            ok_reg        <= 1'b0;
            was_reg       <= 1'b0;
            kind_sel_reg  <= sdtq_pkg::KIND_ACK;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= sdtq_pkg::KIND_ACK;
            out_id_reg    <= '0;
            out_wp_reg    <= 1'b0;
            out_rem_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg   <= cmd_chan.timer_id;
                        now_reg  <= cmd_chan.now;
                        ok_reg   <= id_ok;
                        when_reg <= (cmd_chan.command == sdtq_pkg::CMD_SET_REL)
                                    ? (cmd_chan.time_value + cmd_chan.now)
                                    : cmd_chan.time_value;
                        unique case (cmd_chan.command) inside
                            sdtq_pkg::CMD_SET_ABS,
                            sdtq_pkg::CMD_SET_REL:
                            begin
                                was_reg      <= was_now;
                                kind_sel_reg <= sdtq_pkg::KIND_ACK;
                                if (was_now)
                                begin
                                    pending_reg[in_idx] <= 1'b0;
                                end
                                state_reg <= id_ok ? S_LINK : S_RESP;
                            end
                            sdtq_pkg::CMD_DELETE:
                            begin
                                was_reg      <= was_now;
                                kind_sel_reg <= sdtq_pkg::KIND_ACK;
                                if (was_now)
                                begin
                                    pending_reg[in_idx] <= 1'b0;
                                end
                                state_reg <= S_RESP;
                            end
                            sdtq_pkg::CMD_ADVANCE:
                            begin
                                state_reg <= S_DRAIN;
                            end
                            sdtq_pkg::CMD_QUERY:
                            begin
                                was_reg      <= 1'b0;
                                kind_sel_reg <= sdtq_pkg::KIND_REMAINING;
                                state_reg    <= S_RESP;
                            end
                            default:
                            begin
                                // unused codes are dropped without a result
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_LINK:
                begin
                    pending_reg[idx] <= 1'b1;
                    state_reg        <= S_RESP;
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= kind_sel_reg;
                        out_id_reg    <= id_reg;
                        out_wp_reg    <= was_reg;
                        out_rem_reg   <= (kind_sel_reg == sdtq_pkg::KIND_REMAINING)
                                         ? rem : '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_DRAIN:
                begin
                    // pop the head while it is due; the cell behind it tells
                    // whether this beat closes the burst
                    if (!status.head_due)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_kind_reg          <= sdtq_pkg::KIND_EXPIRED;
                        out_id_reg            <= status.head_id;
                        out_wp_reg            <= 1'b0;
                        out_rem_reg           <= '0;
                        out_last_reg          <= !status.next_due;
                        pending_reg[head_idx] <= 1'b0;
                        if (!status.next_due)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_chan.ready        = (state_reg == S_IDLE);

    assign res_chan.valid        = out_valid_reg;
    assign res_chan.kind         = out_kind_reg;
    assign res_chan.out_timer_id = out_id_reg;
    assign res_chan.was_pending  = out_wp_reg;
    assign res_chan.remaining    = out_rem_reg;
    assign res_chan.last         = out_last_reg;

endmodule

### hdl/sdtq_cell.sv
// ----------------------------------------------------------------------------
// sdtq_cell
// one queue position: holds a timer id and deadline, shifts with neighbours
// ----------------------------------------------------------------------------
module sdtq_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sdtq_pkg::cell_cmd_t      cmd,
    input  sdtq_pkg::entry_t         left_entry,
    input  logic                     left_ge,
    input  sdtq_pkg::entry_t         right_entry,
    input  logic                     found_in,
    output sdtq_pkg::entry_t         entry,
    output logic                     ge,
    output logic                     found_out,
    output logic                     due
);

    logic                                valid_reg;
    logic [sdtq_pkg::ID_W-1:0]           id_reg;
    logic [sdtq_pkg::TIME_W-1:0]         dl_reg;
    sdtq_pkg::entry_t                    entry_next;
    logic                                match;

    assign entry = '{valid: valid_reg, id: id_reg, deadline: dl_reg};

    // empty cells sit at the tail and count as later than any deadline
    assign ge        = !valid_reg || (dl_reg >= cmd.when);
    assign match     = valid_reg && (id_reg == cmd.id);
    assign found_out = found_in || match;
    assign due       = valid_reg && (dl_reg <= cmd.now);

    always_comb
    begin
        entry_next = entry;
        case (cmd.op)
            sdtq_pkg::OP_REMOVE:
            begin
                if (found_out)
                begin
                    entry_next = right_entry;
                end
            end
            sdtq_pkg::OP_INSERT:
            begin
                if (left_ge)
                begin
                    entry_next = left_entry;
                end
                else if (ge)
                begin
                    entry_next = '{valid: 1'b1, id: cmd.id, deadline: cmd.when};
                end
            end
            sdtq_pkg::OP_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= entry_next.id;
        dl_reg <= entry_next.deadline;
    end

endmodule

### hdl/sdtq_chain.sv
// ----------------------------------------------------------------------------
// sdtq_chain
// row of cells ordered soonest deadline first, head at cell zero
// ----------------------------------------------------------------------------
module sdtq_chain #(
    parameter int NUM_CELLS = sdtq_pkg::NUM_TIMERS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sdtq_pkg::cell_cmd_t       cmd,
    output sdtq_pkg::chain_status_t   status
);

    sdtq_pkg::entry_t ents  [NUM_CELLS];
    logic             ge    [NUM_CELLS];
    logic             found [NUM_CELLS];
    logic             due   [NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        sdtq_pkg::entry_t left_e;
        sdtq_pkg::entry_t right_e;
        logic             left_g;
        logic             found_i;

        if (i == 0)
        begin : g_first
            assign left_e  = '0;
            assign left_g  = 1'b0;
            assign found_i = 1'b0;
        end
        else
        begin : g_inner
            assign left_e  = ents[i-1];
            assign left_g  = ge[i-1];
            assign found_i = found[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_body
            assign right_e = ents[i+1];
        end

        sdtq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .found_in    (found_i),
            .entry       (ents[i]),
            .ge          (ge[i]),
            .found_out   (found[i]),
            .due         (due[i])
        );
    end

    assign status.head_due = due[0];
    assign status.head_id  = ents[0].id;
    assign status.next_due = due[1];

endmodule

### tb/tb_sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_deadline_timer_queue
// self-checking bench for the sorted deadline timer queue: a directed opening
// (extreme deadlines, wrap of relative sets, equal-deadline ordering, idle and
// unknown commands) then random command streams around a moving wall time,
// with full-queue flushes and a long result hold-off; every result beat is
// checked against a behavioural copy of the timer list
// ----------------------------------------------------------------------------
module tb_sorted_deadline_timer_queue;

    import sdtq_pkg::*;

    localparam int                NUM_SLOTS    = NUM_TIMERS_DEF;
    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam int                ITEM_TARGET  = 270;
    localparam int                STALL_LIMIT  = 1000;
    localparam int                DRAIN_CYCLES = 40;
    localparam int                HOLD_CYCLES  = 80;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic              was_pending;
        logic [TIME_W-1:0] remaining;
        logic              last;
    } timer_result_t;

    // ------------------------------------------------------------------------
    // behavioural timer list and the results it predicts
    // ------------------------------------------------------------------------
    class timer_scoreboard;

        logic [TIME_W-1:0] due_time [MAX_IDS];
        bit                armed [MAX_IDS];
        int unsigned       by_deadline [$];     // timer ids, soonest first
        timer_result_t     awaited_results [$];
        int unsigned       mismatches;

        task flag_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        function void await_result(kind_t kind, int unsigned id, logic was,
                                   logic [TIME_W-1:0] rem, logic last_flag);
            timer_result_t r;
            r.kind        = kind;
            r.id          = id[ID_W-1:0];
            r.was_pending = was;
            r.remaining   = rem;
            r.last        = last_flag;
            awaited_results.push_back(r);
        endfunction

        function void drop_timer(int unsigned id);
            foreach (by_deadline[i])
            begin
                if (by_deadline[i] == id)
                begin
                    by_deadline.delete(i);
                    break;
                end
            end
            armed[id] = 1'b0;
        endfunction

        // goes in ahead of any timer with the same deadline
        function void arm_timer(int unsigned id, logic [TIME_W-1:0] when);
            int unsigned pos;
            if (by_deadline.size() >= NUM_SLOTS)
                return;
            pos = 0;
            while (pos < by_deadline.size() && due_time[by_deadline[pos]] < when)
                pos++;
            by_deadline.insert(pos, id);
            due_time[id] = when;
            armed[id]    = 1'b1;
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] value, logic [TIME_W-1:0] stamp);
            logic              was;
            logic [TIME_W-1:0] rem;
            int unsigned       fired [$];
            case (op)
                CMD_SET_ABS, CMD_SET_REL:
                begin
                    if (id >= NUM_SLOTS)
                        await_result(KIND_ACK, id, 1'b0, '0, 1'b1);
                    else
                    begin
                        was = armed[id];
                        if (was)
                            drop_timer(id);
                        arm_timer(id, (op == CMD_SET_ABS) ? value : value + stamp);
                        await_result(KIND_ACK, id, was, '0, 1'b1);
                    end
                end
                CMD_DELETE:
                begin
                    was = (id < NUM_SLOTS) && armed[id];
                    if (was)
                        drop_timer(id);
                    await_result(KIND_ACK, id, was, '0, 1'b1);
                end
                CMD_ADVANCE:
                begin
                    while (by_deadline.size() > 0 && fired.size() < NUM_SLOTS)
                    begin
                        if (due_time[by_deadline[0]] > stamp)
                            break;
                        fired.push_back(by_deadline[0]);
                        drop_timer(by_deadline[0]);
                    end
                    foreach (fired[i])
                        await_result(KIND_EXPIRED, fired[i], 1'b0, '0,
                                     i == fired.size() - 1);
                end
                CMD_QUERY:
                begin
                    rem = '0;
                    if (id < NUM_SLOTS && due_time[id] > stamp)
                        rem = due_time[id] - stamp;
                    await_result(KIND_REMAINING, id, 1'b0, rem, 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        task check_result(timer_result_t got);
            timer_result_t want;
            if (awaited_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result kind %0d id %0d",
                                        got.kind, got.id));
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.id !== want.id)
                flag_mismatch($sformatf("timer id %0d, want %0d", got.id, want.id));
            if (got.was_pending !== want.was_pending)
                flag_mismatch($sformatf("id %0d was_pending %0b, want %0b", want.id,
                                        got.was_pending, want.was_pending));
            if (got.remaining !== want.remaining)
                flag_mismatch($sformatf("id %0d remaining %0h, want %0h", want.id,
                                        got.remaining, want.remaining));
            if (got.last !== want.last)
                flag_mismatch($sformatf("id %0d last %0b, want %0b", want.id,
                                        got.last, want.last));
        endtask

        task close_out();
            if (awaited_results.size() != 0)
                flag_mismatch($sformatf("%0d results never arrived",
                                        awaited_results.size()));
        endtask

    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    sdtq_in_if  cmd_chan ();
    sdtq_out_if res_chan ();

    sorted_deadline_timer_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_chan (cmd_chan),
        .res_chan (res_chan)
    );

    timer_scoreboard board = new;

    int unsigned       sent_items;
    int unsigned       hold_request;
    int unsigned       quiet_cycles;
    bit                steady_phase;     // no gaps on either side while set
    bit                ever_set [MAX_IDS];
    logic [TIME_W-1:0] wall_time;

    function automatic int unsigned pause_cycles();
        return steady_phase ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [TIME_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CMD_W-1:0] CMD_LAST_UNKNOWN();
        return CMD_W'($urandom_range(CMD_QUERY + 1, (1 << CMD_W) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // command side: random gap, then hold the beat until it is taken
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] value,
                                input logic [TIME_W-1:0] stamp);
        int unsigned gap;
        gap = pause_cycles();
        repeat (gap)
        begin
            cmd_chan.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_chan.valid      <= 1'b1;
        cmd_chan.command    <= op;
        cmd_chan.timer_id   <= id;
        cmd_chan.time_value <= value;
        cmd_chan.now        <= stamp;
        do
            @(posedge clk);
        while (cmd_chan.ready !== 1'b1);
        board.note_command(op, id, value, stamp);
        // unknown opcodes are dropped by the block and do not count
        if (op <= CMD_QUERY)
            sent_items++;
        if (op == CMD_SET_ABS || op == CMD_SET_REL)
            ever_set[id] = 1'b1;
    endtask

    // arm every slot inside a narrow window so ties are common, then expire
    // the lot in one advance: the longest burst of expired beats
    task automatic flush_burst();
        int unsigned first;
        first = $urandom_range(0, MAX_IDS - 1);
        for (int k = 0; k < MAX_IDS; k++)
            send_command(CMD_SET_ABS, ID_W'((first + k) % MAX_IDS),
                         wall_time + $urandom_range(1, 6), random_word());
        wall_time = wall_time + 6;
        send_command(CMD_ADVANCE, ID_W'($urandom), random_word(), wall_time);
    endtask

    task automatic random_command();
        int unsigned       pick;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] value;
        logic [TIME_W-1:0] stamp;
        pick  = $urandom_range(0, 99);
        id    = ID_W'($urandom_range(0, MAX_IDS - 1));
        stamp = ($urandom_range(0, 9) == 0) ? random_word() : wall_time;
        if ($urandom_range(0, 59) == 0)
            flush_burst();
        else if (pick < 28)
        begin
            value = ($urandom_range(0, 9) == 0) ? random_word()
                                                : wall_time + $urandom_range(0, 200);
            send_command(CMD_SET_ABS, id, value, random_word());
        end
        else if (pick < 46)
        begin
            value = ($urandom_range(0, 9) == 0) ? random_word() : $urandom_range(0, 200);
            send_command(CMD_SET_REL, id, value, stamp);
        end
        else if (pick < 56)
            send_command(CMD_DELETE, id, random_word(), random_word());
        else if (pick < 70)
        begin
            // only slots whose deadline has been written at least once
            while (!ever_set[id])
                id = ID_W'($urandom_range(0, MAX_IDS - 1));
            send_command(CMD_QUERY, id, random_word(), stamp);
        end
        else if (pick < 94)
        begin
            wall_time = wall_time + $urandom_range(0, 120);
            if (stamp != wall_time - $urandom_range(0, 120) && $urandom_range(0, 9) != 0)
                stamp = wall_time;
            send_command(CMD_ADVANCE, id, random_word(), stamp);
        end
        else
            send_command(CMD_LAST_UNKNOWN(), id, random_word(), random_word());
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall before each beat, plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned   stall;
        timer_result_t got;
        res_chan.ready <= 1'b0;
        wait (rst_n === 1'b1);
        stall = pause_cycles();
        forever
        begin
            if (hold_request != 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            res_chan.ready <= (stall == 0);
            if (stall != 0)
                stall--;
            @(posedge clk);
            if (res_chan.valid === 1'b1 && res_chan.ready === 1'b1)
            begin
                got.kind        = kind_t'(res_chan.kind);
                got.id          = res_chan.out_timer_id;
                got.was_pending = res_chan.was_pending;
                got.remaining   = res_chan.remaining;
                got.last        = res_chan.last;
                board.check_result(got);
                stall = pause_cycles();
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with no beat on either channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((cmd_chan.valid === 1'b1 && cmd_chan.ready === 1'b1) ||
            (res_chan.valid === 1'b1 && res_chan.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit held;
        bit wrapped;
        held                 = 1'b0;
        wrapped              = 1'b0;
        sent_items           = 0;
        hold_request         = 0;
        quiet_cycles         = 0;
        steady_phase         = 1'b0;
        wall_time            = '0;
        foreach (ever_set[i])
            ever_set[i] = 1'b0;
        rst_n               <= 1'b0;
        cmd_chan.valid      <= 1'b0;
        cmd_chan.command    <= CMD_SET_ABS;
        cmd_chan.timer_id   <= '0;
        cmd_chan.time_value <= '0;
        cmd_chan.now        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance on an empty queue and delete of an idle slot
        send_command(CMD_ADVANCE, 4'd0, '0, '0);
        send_command(CMD_DELETE, 4'd4, TIME_MAX, TIME_MAX);
        // extreme deadlines, relative set that wraps past the top
        send_command(CMD_SET_ABS, 4'd0, '0, TIME_MAX);
        send_command(CMD_SET_ABS, 4'd15, TIME_MAX, '0);
        send_command(CMD_SET_REL, 4'd1, TIME_MAX, 64'd2);
        // equal deadlines: the later set goes in front, a re-set moves ahead again
        send_command(CMD_SET_ABS, 4'd2, 64'd5, '0);
        send_command(CMD_SET_ABS, 4'd3, 64'd5, '0);
        send_command(CMD_SET_ABS, 4'd2, 64'd5, '0);
        // remaining at its top and saturated to zero
        send_command(CMD_QUERY, 4'd15, '0, '0);
        send_command(CMD_QUERY, 4'd0, '0, TIME_MAX);
        send_command(CMD_SET_REL, 4'd5, TIME_MAX, TIME_MAX);
        send_command(CMD_DELETE, 4'd3, '0, '0);
        // idle slot still answers from its last deadline
        send_command(CMD_QUERY, 4'd3, '0, 64'd1);
        for (int c = CMD_QUERY + 1; c < (1 << CMD_W); c++)
            send_command(CMD_W'(c), 4'd9, random_word(), random_word());
        send_command(CMD_ADVANCE, 4'd0, '0, 64'd5);
        send_command(CMD_QUERY, 4'd5, '0, TIME_MAX - 2);
        send_command(CMD_ADVANCE, 4'd0, '0, TIME_MAX);
        send_command(CMD_SET_ABS, 4'd6, {16{4'hA}}, {16{4'h5}});
        send_command(CMD_SET_ABS, 4'd7, {16{4'h5}}, {16{4'hA}});
        send_command(CMD_ADVANCE, 4'd7, {16{4'hA}}, {16{4'h5}});
        send_command(CMD_DELETE, 4'd6, {16{4'h5}}, {16{4'hA}});

        wall_time = 64'd100;
        while (sent_items < ITEM_TARGET)
        begin
            steady_phase = (sent_items % 90) >= 65;
            if (!held && sent_items >= 120)
            begin
                // starve the result side so the block backs up into the input
                hold_request = HOLD_CYCLES;
                held         = 1'b1;
            end
            if (!wrapped && sent_items >= 170)
            begin
                // carry on just below the top of the time range
                wall_time = TIME_MAX - 250;
                wrapped   = 1'b1;
            end
            random_command();
        end
        cmd_chan.valid <= 1'b0;

        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
